// ===== sv/bpfa_pkg.sv =====
// Shared types, codes and helper functions for the page frame allocator.
package bpfa_pkg;

  // Command codes on func
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_CHECK = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_REGION = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  localparam int AddrW = 48;
  localparam int LenW  = 17;
  // bitmap bytes of the largest page count the length field can carry
  localparam int NbW   = 15;

  // Bitmap bytes needed for a page count, rounded up
  function automatic logic [NbW-1:0] bytes_of(input logic [LenW-1:0] pages);
    logic [LenW:0] sum;
    sum = {1'b0, pages} + (LenW+1)'(7);
    return sum[NbW+2:3];
  endfunction

  // Lowest clear bit of a bitmap byte
  function automatic logic [2:0] first_zero(input logic [7:0] v);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) k = 3'(i);
    end
    return k;
  endfunction

endpackage

// ===== sv/bpfa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
module bpfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bpfa_mod.sv =====
// Iterative remainder unit: one restoring division step per cycle.
module bpfa_mod #(
  parameter int Width = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             done,
  output logic [Width-1:0] remainder
);

  localparam int CntW = $clog2(Width + 1);

  logic             run;
  logic [CntW-1:0]  cnt;
  logic [Width-1:0] quo;
  logic [Width-1:0] dsr;
  logic [Width:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {remainder, quo[Width-1]};
    if (trial >= {1'b0, dsr}) begin
      trial = trial - {1'b0, dsr};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CntW'(1);
        if (32'(cnt) == Width - 1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (run) begin
      quo       <= quo << 1;
      remainder <= trial[Width-1:0];
    end
  end

endmodule

// ===== sv/bitmap_page_frame_allocator_core.sv =====
// Top level: bitmap page frame allocator with region table and used-bitmap RAMs.
//
//  channel   | signals                                            | handshake
//  ----------+----------------------------------------------------+----------------------
//  command   | func region_number address length_pages usable     | start & !busy
//  result    | status frame_address page_used                     | done, one cycle
//  config    | cfg_wdata (region_count)                           | cfg_we
//
// One word at a time. Load writes one bitmap byte per cycle. Alloc runs the
// remainder unit to pick the start region, then reads each region entry in turn,
// runs the remainder unit again for the start byte of a region with free pages,
// and reads bitmap bytes one at a time (one bitmap RAM read port). Free and
// check read one region entry per binary-search probe, then the page's bitmap
// byte. rst is synchronous; a valid bit per region slot makes unloaded slots read
// as empty, so no clearing pass runs. The receiver cannot stall results.
module bitmap_page_frame_allocator_core #(
  parameter int MAX_REGIONS = 16,
  parameter int TOTAL_PAGES = 65536,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [3:0]  region_number,
  input  logic [47:0] address,
  input  logic [16:0] length_pages,
  input  logic        usable,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [47:0] frame_address,
  output logic        page_used
);

  localparam int SB   = TOTAL_PAGES / 8;
  localparam int BW   = (SB > 1) ? $clog2(SB) : 1;
  localparam int FW   = $clog2(SB + 1);
  localparam int RW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int NW   = $clog2(MAX_REGIONS + 1);
  localparam int NBW  = bpfa_pkg::NbW;
  localparam int LW   = bpfa_pkg::LenW;
  localparam int AW   = bpfa_pkg::AddrW;
  localparam int MW0  = (BW > NBW) ? BW : NBW;
  localparam int MW1  = (NW > RW) ? NW : RW;
  localparam int MW   = (MW0 > MW1) ? MW0 : MW1;
  localparam int EntW = AW + LW + LW + FW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_LOAD  = 11'b000_0000_0010,
    S_AMOD1 = 11'b000_0000_0100,
    S_AREG  = 11'b000_0000_1000,
    S_AEVAL = 11'b000_0001_0000,
    S_AMOD2 = 11'b000_0010_0000,
    S_ARD   = 11'b000_0100_0000,
    S_ACHK  = 11'b000_1000_0000,
    S_SRD   = 11'b001_0000_0000,
    S_SEVAL = 11'b010_0000_0000,
    S_BCHK  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // Control and cursor registers
  logic [4:0]        region_count;
  logic [FW-1:0]     fill, fill_next;
  logic [RW-1:0]     rcur, rcur_next;
  logic [BW-1:0]     bcur, bcur_next;
  logic              done_next;
  logic [MAX_REGIONS-1:0] loaded;
  logic              rg_rvalid;

  // Working registers
  logic [1:0]        fn, fn_next;
  logic [3:0]        slot, slot_next;
  logic [AW-1:0]     addr_q, addr_q_next;
  logic [LW-1:0]     len_q, len_q_next;
  logic              usable_q, usable_q_next;
  logic [NBW-1:0]    nb, nb_next;
  logic [NBW:0]      cnt, cnt_next;
  logic [NW-1:0]     ri, ri_next;
  logic [RW-1:0]     r, r_next;
  logic [BW-1:0]     b, b_next;
  logic signed [NW:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic [AW-1:0]     ent_base, ent_base_next;
  logic [LW-1:0]     ent_size, ent_size_next;
  logic [LW-1:0]     ent_free, ent_free_next;
  logic [FW-1:0]     ent_off, ent_off_next;
  logic [2:0]        bit_pos, bit_pos_next;
  logic [1:0]        status_next;
  logic [AW-1:0]     pa_next;
  logic              pu_next;

  // RAM ports
  logic              rg_we;
  logic [RW-1:0]     rg_waddr, rg_raddr;
  logic [EntW-1:0]   rg_wdata, rg_rdata, rg_word;
  logic              bm_we;
  logic [BW-1:0]     bm_waddr, bm_raddr;
  logic [7:0]        bm_wdata, bm_rdata;

  // Remainder unit
  logic              mod_start, mod_done;
  logic [MW-1:0]     mod_a, mod_b, mod_rem;

  // Decoded region word and helpers
  logic [AW-1:0]     rd_base;
  logic [LW-1:0]     rd_size, rd_free;
  logic [FW-1:0]     rd_off;
  logic [NW-1:0]     n_act;
  logic [AW:0]       rd_end;
  logic [AW-1:0]     rel;
  logic [LW-1:0]     pg;
  logic [7:0]        load_byte;
  logic [2:0]        k;
  logic              last_region;
  logic [RW-1:0]     r_wrap;

  // Unloaded slots read as an empty region
  assign rg_word = rg_rvalid ? rg_rdata : '0;
  assign rd_base = rg_word[EntW-1 -: AW];
  assign rd_size = rg_word[FW+2*LW-1 -: LW];
  assign rd_free = rg_word[FW+LW-1 -: LW];
  assign rd_off  = rg_word[FW-1:0];

  assign n_act = (32'(region_count) > MAX_REGIONS) ? NW'(MAX_REGIONS) : NW'(region_count);
  assign rd_end = {1'b0, rd_base} + ((AW+1)'(rd_size) << PAGE_SHIFT);
  assign rel    = addr_q - rd_base;
  assign pg     = rel[PAGE_SHIFT+LW-1:PAGE_SHIFT];
  assign k      = bpfa_pkg::first_zero(bm_rdata);
  assign last_region = (32'(ri) + 1 >= 32'(n_act));
  assign r_wrap = (32'(r) + 1 == 32'(n_act)) ? '0 : r + RW'(1);
  assign busy   = (state != S_IDLE);

  // Pad bits past the last page of a region read as used
  always_comb begin
    load_byte = usable_q ? 8'h00 : 8'hFF;
    if ((32'(cnt) + 1 == 32'(nb)) && (len_q[2:0] != 3'd0)) begin
      load_byte = load_byte | (8'hFF << len_q[2:0]);
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    rcur_next     = rcur;
    bcur_next     = bcur;
    done_next     = 1'b0;
    fn_next       = fn;
    slot_next     = slot;
    addr_q_next   = addr_q;
    len_q_next    = len_q;
    usable_q_next = usable_q;
    nb_next       = nb;
    cnt_next      = cnt;
    ri_next       = ri;
    r_next        = r;
    b_next        = b;
    lo_next       = lo;
    hi_next       = hi;
    mid_next      = mid;
    ent_base_next = ent_base;
    ent_size_next = ent_size;
    ent_free_next = ent_free;
    ent_off_next  = ent_off;
    bit_pos_next  = bit_pos;
    status_next   = status;
    pa_next       = frame_address;
    pu_next       = page_used;
    rg_we    = 1'b0;
    rg_waddr = r;
    rg_wdata = {ent_base, ent_size, ent_free, ent_off};
    rg_raddr = r;
    bm_we    = 1'b0;
    bm_waddr = BW'(32'(fill) + 32'(cnt));
    bm_wdata = load_byte;
    bm_raddr = BW'(32'(ent_off) + 32'(b));
    mod_start = 1'b0;
    mod_a     = MW'(rcur);
    mod_b     = MW'(n_act);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          fn_next       = func;
          slot_next     = region_number;
          addr_q_next   = address;
          len_q_next    = length_pages;
          usable_q_next = usable;
          nb_next       = bpfa_pkg::bytes_of(length_pages);
          cnt_next      = '0;
          ri_next       = '0;
          lo_next       = '0;
          hi_next       = $signed({1'b0, n_act}) - (NW+1)'(1);
          status_next   = bpfa_pkg::ST_OK;
          pa_next       = '0;
          pu_next       = 1'b0;
          unique case (bpfa_pkg::func_t'(func))
            bpfa_pkg::FUNC_LOAD: begin
              if (32'(region_number) >= MAX_REGIONS) begin
                done_next = 1'b1;
              end else if (32'(fill) + 32'(bpfa_pkg::bytes_of(length_pages)) > SB) begin
                status_next = bpfa_pkg::ST_OVERFLOW;
                done_next   = 1'b1;
              end else if (length_pages == '0) begin
                // empty region: table entry only
                rg_we     = 1'b1;
                rg_waddr  = RW'(region_number);
                rg_wdata  = {address, length_pages, LW'(0), fill};
                done_next = 1'b1;
              end else begin
                state_next = S_LOAD;
              end
            end
            bpfa_pkg::FUNC_ALLOC: begin
              if (n_act == '0) begin
                status_next = bpfa_pkg::ST_NO_FREE;
                done_next   = 1'b1;
              end else begin
                mod_start  = 1'b1;
                state_next = S_AMOD1;
              end
            end
            bpfa_pkg::FUNC_FREE, bpfa_pkg::FUNC_CHECK: begin
              state_next = S_SRD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // Fill the new region's bitmap, one byte a cycle
      S_LOAD: begin
        bm_we    = 1'b1;
        cnt_next = cnt + (NBW+1)'(1);
        if (32'(cnt) + 1 == 32'(nb)) begin
          rg_we      = 1'b1;
          rg_waddr   = RW'(slot);
          rg_wdata   = {addr_q, len_q, usable_q ? len_q : LW'(0), fill};
          fill_next  = FW'(32'(fill) + 32'(nb));
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Start region is region_cursor mod active count
      S_AMOD1: begin
        if (mod_done) begin
          r_next     = RW'(mod_rem);
          state_next = S_AREG;
        end
      end

      S_AREG: begin
        rg_raddr   = r;
        state_next = S_AEVAL;
      end

      // Skip full or empty regions, else start the byte walk
      S_AEVAL: begin
        ent_base_next = rd_base;
        ent_size_next = rd_size;
        ent_free_next = rd_free;
        ent_off_next  = rd_off;
        nb_next       = bpfa_pkg::bytes_of(rd_size);
        if (rd_free == '0 || rd_size == '0) begin
          if (last_region) begin
            status_next = bpfa_pkg::ST_NO_FREE;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ri_next    = ri + NW'(1);
            r_next     = r_wrap;
            state_next = S_AREG;
          end
        end else begin
          rcur_next  = r;
          mod_start  = 1'b1;
          mod_a      = MW'(bcur);
          mod_b      = MW'(bpfa_pkg::bytes_of(rd_size));
          cnt_next   = '0;
          state_next = S_AMOD2;
        end
      end

      S_AMOD2: begin
        if (mod_done) begin
          b_next     = BW'(mod_rem);
          state_next = S_ARD;
        end
      end

      S_ARD: begin
        bm_raddr   = BW'(32'(ent_off) + 32'(b));
        state_next = S_ACHK;
      end

      // Take the lowest clear bit, or advance byte / region
      S_ACHK: begin
        if (bm_rdata != 8'hFF) begin
          bcur_next   = b;
          bm_we       = 1'b1;
          bm_waddr    = BW'(32'(ent_off) + 32'(b));
          bm_wdata    = bm_rdata | (8'h01 << k);
          rg_we       = 1'b1;
          rg_waddr    = r;
          rg_wdata    = {ent_base, ent_size, ent_free - LW'(1), ent_off};
          pa_next     = ent_base + (AW'({b, k}) << PAGE_SHIFT);
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (32'(cnt) + 1 == 32'(nb)) begin
          if (last_region) begin
            status_next = bpfa_pkg::ST_NO_FREE;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ri_next    = ri + NW'(1);
            r_next     = r_wrap;
            state_next = S_AREG;
          end
        end else begin
          cnt_next   = cnt + (NBW+1)'(1);
          b_next     = (32'(b) + 1 == 32'(nb)) ? '0 : b + BW'(1);
          state_next = S_ARD;
        end
      end

      // Binary search probe
      S_SRD: begin
        mid_next = lo + ((hi - lo) >>> 1);
        rg_raddr = RW'(lo + ((hi - lo) >>> 1));
        if (lo > hi) begin
          status_next = bpfa_pkg::ST_NO_REGION;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_SEVAL;
        end
      end

      S_SEVAL: begin
        ent_base_next = rd_base;
        ent_size_next = rd_size;
        ent_free_next = rd_free;
        ent_off_next  = rd_off;
        bit_pos_next  = pg[2:0];
        bm_raddr      = BW'(32'(rd_off) + 32'(pg[LW-1:3]));
        if (rd_base > addr_q) begin
          hi_next    = mid - (NW+1)'(1);
          state_next = S_SRD;
        end else if ({1'b0, addr_q} >= rd_end) begin
          lo_next    = mid + (NW+1)'(1);
          state_next = S_SRD;
        end else begin
          b_next     = BW'(32'(rd_off) + 32'(pg[LW-1:3]));
          state_next = S_BCHK;
        end
      end

      // Report or clear the page's bit
      S_BCHK: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (fn == bpfa_pkg::FUNC_CHECK) begin
          pu_next = bm_rdata[bit_pos];
        end else if (bm_rdata[bit_pos]) begin
          bm_we    = 1'b1;
          bm_waddr = b;
          bm_wdata = bm_rdata & ~(8'h01 << bit_pos);
          rg_we    = 1'b1;
          rg_waddr = RW'(mid);
          rg_wdata = {ent_base, ent_size, ent_free + LW'(1), ent_off};
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      rcur         <= '0;
      bcur         <= '0;
      region_count <= '0;
      done         <= 1'b0;
      loaded       <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      rcur  <= rcur_next;
      bcur  <= bcur_next;
      done  <= done_next;
      if (cfg_we) begin
        region_count <= cfg_wdata;
      end
      if (rg_we) begin
        loaded[rg_waddr] <= 1'b1;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    fn            <= fn_next;
    slot          <= slot_next;
    addr_q        <= addr_q_next;
    len_q         <= len_q_next;
    usable_q      <= usable_q_next;
    nb            <= nb_next;
    cnt           <= cnt_next;
    ri            <= ri_next;
    r             <= r_next;
    b             <= b_next;
    lo            <= lo_next;
    hi            <= hi_next;
    mid           <= mid_next;
    ent_base      <= ent_base_next;
    ent_size      <= ent_size_next;
    ent_free      <= ent_free_next;
    ent_off       <= ent_off_next;
    bit_pos       <= bit_pos_next;
    status        <= status_next;
    frame_address <= pa_next;
    page_used     <= pu_next;
    rg_rvalid     <= loaded[rg_raddr];
  end

  bpfa_ram #(.Width(EntW), .Depth(MAX_REGIONS)) u_region_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .raddr (rg_raddr),
    .rdata (rg_rdata)
  );

  bpfa_ram #(.Width(8), .Depth(SB)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bpfa_mod #(.Width(MW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_a),
    .divisor   (mod_b),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // A result word appears only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result word while sequencer busy");

  // An accepted word either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word dropped");

  // The bitmap store is never overcommitted
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= SB)
    else $error("bitmap fill beyond store");

  // Remainder results land only where the sequencer waits for them
  a_mod_owner: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_AMOD1 || state == S_AMOD2))
    else $error("stray remainder result");

endmodule
